@@ rtl/cca_pkg.sv @@
// Shared types, codes and helpers for the CIGAR coverage accumulator.
// Used by the top level, cca_span and cca_seq; depends on nothing.
package cca_pkg;

  localparam int unsigned SitesDefault = 1024;
  localparam int unsigned SitesMax     = 65536;
  // Overlap fits SitesMax, an entry offset fits SitesMax-1
  localparam int unsigned OvlW = 17;
  localparam int unsigned OffW = 16;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 31;
  localparam logic [10:0] IntervalLengthReset = 11'd1024;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INTERVAL_START  = 1'b0,
    CFG_INTERVAL_LENGTH = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_CIGAR = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    CIG_M  = 4'd0,
    CIG_I  = 4'd1,
    CIG_D  = 4'd2,
    CIG_N  = 4'd3,
    CIG_S  = 4'd4,
    CIG_H  = 4'd5,
    CIG_P  = 4'd6,
    CIG_EQ = 4'd7,
    CIG_X  = 4'd8
  } cigar_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPAN,
    ST_WALK,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [23:0] depth;
    logic [31:0] ins_sum;
    logic [31:0] del_sum;
    logic [39:0] clip_sum;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Span of one cigar operation clipped to the interval
  typedef struct packed {
    logic            nonempty;
    logic [OvlW-1:0] ovl;
    logic [OffW-1:0] off;
    logic            cur_ge;
    logic [31:0]     cursor_next;
  } span_t;

  function automatic logic [10:0] sites_in_use(logic [10:0] len, logic [16:0] sites);
    return ({6'b0, len} > sites) ? sites[10:0] : len;
  endfunction

endpackage

@@ rtl/cca_in_if.sv @@
// Input channel of the CIGAR coverage accumulator: valid/ready plus item fields.
// Depends on nothing.
interface cca_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [30:0] ref_pos;
  logic [15:0] clip_bases;
  logic        on_contig;
  logic [3:0]  cigar_code;
  logic [27:0] op_length;
  logic [9:0]  site_index;

  modport source (
    output valid, operation, ref_pos, clip_bases, on_contig, cigar_code, op_length,
           site_index,
    input  ready
  );
  modport sink (
    input  valid, operation, ref_pos, clip_bases, on_contig, cigar_code, op_length,
           site_index,
    output ready
  );
endinterface

@@ rtl/cca_out_if.sv @@
// Result channel of the CIGAR coverage accumulator: valid/ready plus site fields.
// Depends on nothing.
interface cca_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] depth;
  logic [31:0] ins_sum;
  logic [31:0] del_sum;
  logic [39:0] clip_sum;
  logic [47:0] aligned_total;

  modport source (
    output valid, depth, ins_sum, del_sum, clip_sum, aligned_total,
    input  ready
  );
  modport sink (
    input  valid, depth, ins_sum, del_sum, clip_sum, aligned_total,
    output ready
  );
endinterface

@@ rtl/cigar_coverage_accumulator.sv @@
// CIGAR coverage accumulator, top level: config registers, span unit, sequencer, table.
// Begin items and cigar items that touch nothing (S, H, P, unknown, no open read) leave
// the sequencer idle. M, =, X, D, I and N go through the span unit; M, =, X, D and I that
// touch sites then do one table read-modify-write per site and a final write-back.
// A read-out reads the entry into the RAM output register, then loads the result register
// once it is free; a clear writes zero to every entry. Reset sweeps the table the same way.
module cigar_coverage_accumulator #(
  parameter int unsigned SITES = cca_pkg::SitesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cca_in_if.sink                        in_i,
  cca_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [cca_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cca_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int unsigned AW = (SITES > 1) ? $clog2(SITES) : 1;

  logic [30:0] iv_start_q;
  logic [10:0] iv_len_q;

  logic                       span_start;
  logic [31:0]                span_cursor;
  logic [27:0]                span_len;
  logic                       span_done;
  cca_pkg::span_t             span;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [cca_pkg::EntryW-1:0] ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [cca_pkg::EntryW-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_start_q <= '0;
      iv_len_q   <= cca_pkg::IntervalLengthReset;
    end else if (cfg_we_i) begin
      unique case (cca_pkg::cfg_reg_e'(cfg_idx_i))
        cca_pkg::CFG_INTERVAL_START:  iv_start_q <= cfg_wdata_i;
        cca_pkg::CFG_INTERVAL_LENGTH: iv_len_q   <= cfg_wdata_i[10:0];
      endcase
    end
  end

  cca_span #(
    .SITES (SITES)
  ) u_span (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (span_start),
    .cursor_i   (span_cursor),
    .len_i      (span_len),
    .iv_start_i (iv_start_q),
    .iv_len_i   (iv_len_q),
    .done_o     (span_done),
    .span_o     (span)
  );

  cca_seq #(
    .SITES (SITES),
    .AW    (AW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .out_o         (out_o),
    .iv_len_i      (iv_len_q),
    .span_start_o  (span_start),
    .span_cursor_o (span_cursor),
    .span_len_o    (span_len),
    .span_done_i   (span_done),
    .span_i        (span),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

  cca_ram #(
    .WIDTH (cca_pkg::EntryW),
    .DEPTH (SITES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

@@ rtl/cca_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module cca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cca_span.sv @@
// Three-stage span unit: clips a cigar operation's reference span to the interval.
// Depends on cca_pkg (span_t, sites_in_use).
module cca_span #(
  parameter int unsigned SITES = cca_pkg::SitesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         cursor_i,
  input  logic [27:0]         len_i,
  input  logic [30:0]         iv_start_i,
  input  logic [10:0]         iv_len_i,
  output logic                done_o,
  output cca_pkg::span_t      span_o
);

  localparam logic [16:0] SitesC = 17'(SITES);

  logic        v1_q, v2_q, v3_q;
  logic [31:0] lo_q;
  logic [32:0] hi_q;
  logic [30:0] ivlo_q, ivlo2_q;
  logic [31:0] ivhi_q;
  logic [31:0] a_q;
  logic [32:0] b_q;
  logic        cur_ge_q;
  logic [31:0] cnext_q;
  cca_pkg::span_t span_q;

  logic        ge_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign ge_d = lo_q >= {1'b0, ivlo_q};

  always_ff @(posedge clk_i) begin
    // Stage 1: span end and interval end
    lo_q   <= cursor_i;
    hi_q   <= {1'b0, cursor_i} + 33'(len_i);
    ivlo_q <= iv_start_i;
    ivhi_q <= {1'b0, iv_start_i} + 32'(cca_pkg::sites_in_use(iv_len_i, SitesC));
    // Stage 2: intersect
    a_q      <= ge_d ? lo_q : {1'b0, ivlo_q};
    b_q      <= (hi_q < {1'b0, ivhi_q}) ? hi_q : {1'b0, ivhi_q};
    cur_ge_q <= ge_d;
    cnext_q  <= hi_q[32] ? '1 : hi_q[31:0];
    ivlo2_q  <= ivlo_q;
    // Stage 3: length and table offset
    span_q.nonempty    <= b_q > {1'b0, a_q};
    span_q.ovl         <= cca_pkg::OvlW'(b_q - {1'b0, a_q});
    span_q.off         <= cca_pkg::OffW'(a_q - {1'b0, ivlo2_q});
    span_q.cur_ge      <= cur_ge_q;
    span_q.cursor_next <= cnext_q;
  end

  assign done_o = v3_q;
  assign span_o = span_q;

endmodule

@@ rtl/cca_seq.sv @@
// Sequencer: takes items, walks the site table read-modify-write, clears it, reads out.
// Depends on cca_pkg, cca_in_if, cca_out_if; drives cca_span and the table RAM.
module cca_seq #(
  parameter int unsigned SITES = cca_pkg::SitesDefault,
  parameter int unsigned AW    = (SITES > 1) ? $clog2(SITES) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  cca_in_if.sink                     in_i,
  cca_out_if.source                  out_o,
  input  logic [10:0]                iv_len_i,
  output logic                       span_start_o,
  output logic [31:0]                span_cursor_o,
  output logic [27:0]                span_len_o,
  input  logic                       span_done_i,
  input  cca_pkg::span_t             span_i,
  output logic                       ram_we_o,
  output logic [AW-1:0]              ram_waddr_o,
  output logic [cca_pkg::EntryW-1:0] ram_wdata_o,
  output logic                       ram_re_o,
  output logic [AW-1:0]              ram_raddr_o,
  input  logic [cca_pkg::EntryW-1:0] ram_rdata_i
);

  localparam int unsigned RemW   = $clog2(SITES + 1);
  localparam logic [16:0] SitesC = 17'(SITES);
  localparam logic [AW-1:0] LastAddr = AW'(SITES - 1);

  cca_pkg::state_e state_q, state_d;
  logic [31:0] cursor_q, cursor_d;
  logic [15:0] clip_q, clip_d;
  logic        active_q, active_d;
  logic [47:0] total_q, total_d;
  logic [27:0] len_q, len_d;
  logic        inc_depth_q, inc_depth_d;
  logic        add_clip_q, add_clip_d;
  logic        add_del_q, add_del_d;
  logic        add_ins_q, add_ins_d;
  logic        add_total_q, add_total_d;
  logic        advance_q, advance_d;
  logic        walk_q, walk_d;
  logic [AW-1:0]   rd_addr_q, rd_addr_d;
  logic [AW-1:0]   wr_addr_q, wr_addr_d;
  logic [RemW-1:0] remain_q, remain_d;
  logic        pend_q, pend_d;
  logic        first_q, first_d;
  logic        first_wr_q, first_wr_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic        in_range_q, in_range_d;
  logic        out_valid_q, out_valid_d;
  cca_pkg::entry_t out_entry_q, out_entry_d;
  logic [47:0] out_total_q, out_total_d;

  logic            accept;
  logic [10:0]     sites_used;
  cca_pkg::entry_t cur_e, upd_e;
  logic [40:0]     clip_sum;
  logic [32:0]     ins_sum, del_sum;
  logic [48:0]     total_sum;

  assign sites_used = cca_pkg::sites_in_use(iv_len_i, SitesC);
  assign in_i.ready = (state_q == cca_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Modify one table entry on its way back
  always_comb begin
    cur_e    = cca_pkg::entry_t'(ram_rdata_i);
    upd_e    = cur_e;
    clip_sum = {1'b0, cur_e.clip_sum} + 41'(clip_q);
    ins_sum  = {1'b0, cur_e.ins_sum} + 33'(len_q);
    del_sum  = {1'b0, cur_e.del_sum} + 33'(len_q);
    if (inc_depth_q && (cur_e.depth != '1)) begin
      upd_e.depth = cur_e.depth + 1'b1;
    end
    if (add_clip_q) begin
      upd_e.clip_sum = clip_sum[40] ? '1 : clip_sum[39:0];
    end
    if (add_ins_q && first_wr_q) begin
      upd_e.ins_sum = ins_sum[32] ? '1 : ins_sum[31:0];
    end
    if (add_del_q && first_wr_q) begin
      upd_e.del_sum = del_sum[32] ? '1 : del_sum[31:0];
    end
  end

  assign total_sum = {1'b0, total_q} + 49'(span_i.ovl);

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    clip_d      = clip_q;
    active_d    = active_q;
    total_d     = total_q;
    len_d       = len_q;
    inc_depth_d = inc_depth_q;
    add_clip_d  = add_clip_q;
    add_del_d   = add_del_q;
    add_ins_d   = add_ins_q;
    add_total_d = add_total_q;
    advance_d   = advance_q;
    walk_d      = walk_q;
    rd_addr_d   = rd_addr_q;
    wr_addr_d   = wr_addr_q;
    remain_d    = remain_q;
    pend_d      = pend_q;
    first_d     = first_q;
    first_wr_d  = first_wr_q;
    clr_cnt_d   = clr_cnt_q;
    in_range_d  = in_range_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_entry_d = out_entry_q;
    out_total_d = out_total_q;

    span_start_o  = 1'b0;
    span_cursor_o = cursor_q;
    span_len_o    = in_i.op_length;
    ram_we_o      = 1'b0;
    ram_waddr_o   = wr_addr_q;
    ram_wdata_o   = upd_e;
    ram_re_o      = 1'b0;
    ram_raddr_o   = rd_addr_q;

    unique case (state_q)
      cca_pkg::ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_cnt_q;
        ram_wdata_o = '0;
        if (clr_cnt_q == LastAddr) begin
          state_d = cca_pkg::ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end

      cca_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cca_pkg::op_e'(in_i.operation))
            cca_pkg::OP_BEGIN: begin
              cursor_d = {1'b0, in_i.ref_pos};
              clip_d   = in_i.clip_bases;
              active_d = in_i.on_contig;
            end
            cca_pkg::OP_CIGAR: begin
              len_d       = in_i.op_length;
              inc_depth_d = 1'b0;
              add_clip_d  = 1'b0;
              add_del_d   = 1'b0;
              add_ins_d   = 1'b0;
              add_total_d = 1'b0;
              advance_d   = 1'b0;
              walk_d      = 1'b0;
              if (active_q) begin
                case (cca_pkg::cigar_e'(in_i.cigar_code))
                  cca_pkg::CIG_M, cca_pkg::CIG_EQ, cca_pkg::CIG_X: begin
                    inc_depth_d  = 1'b1;
                    add_clip_d   = 1'b1;
                    add_total_d  = 1'b1;
                    advance_d    = 1'b1;
                    walk_d       = 1'b1;
                    span_start_o = 1'b1;
                    state_d      = cca_pkg::ST_SPAN;
                  end
                  cca_pkg::CIG_D: begin
                    inc_depth_d  = 1'b1;
                    add_del_d    = 1'b1;
                    advance_d    = 1'b1;
                    walk_d       = 1'b1;
                    span_start_o = 1'b1;
                    state_d      = cca_pkg::ST_SPAN;
                  end
                  cca_pkg::CIG_I: begin
                    // one-site span at the cursor tells whether it is inside
                    add_ins_d    = 1'b1;
                    walk_d       = 1'b1;
                    span_len_o   = 28'd1;
                    span_start_o = 1'b1;
                    state_d      = cca_pkg::ST_SPAN;
                  end
                  cca_pkg::CIG_N: begin
                    advance_d    = 1'b1;
                    span_start_o = 1'b1;
                    state_d      = cca_pkg::ST_SPAN;
                  end
                  default: begin
                  end
                endcase
              end
            end
            cca_pkg::OP_READ: begin
              ram_re_o    = 1'b1;
              ram_raddr_o = AW'(in_i.site_index);
              in_range_d  = {1'b0, in_i.site_index} < sites_used;
              state_d     = cca_pkg::ST_READ;
            end
            cca_pkg::OP_CLEAR: begin
              total_d   = '0;
              clr_cnt_d = '0;
              state_d   = cca_pkg::ST_CLEAR;
            end
          endcase
        end
      end

      cca_pkg::ST_SPAN: begin
        if (span_done_i) begin
          if (advance_q) begin
            cursor_d = span_i.cursor_next;
          end
          if (add_total_q && span_i.nonempty) begin
            total_d = total_sum[48] ? '1 : total_sum[47:0];
          end
          // deletion length lands only when the cursor itself is in range
          add_del_d = add_del_q && span_i.cur_ge;
          rd_addr_d = AW'(span_i.off);
          remain_d  = (span_i.nonempty && walk_q) ? RemW'(span_i.ovl) : '0;
          first_d   = 1'b1;
          pend_d    = 1'b0;
          state_d   = cca_pkg::ST_WALK;
        end
      end

      cca_pkg::ST_WALK: begin
        // read site p while writing back site p-1
        if (remain_q != '0) begin
          ram_re_o   = 1'b1;
          rd_addr_d  = rd_addr_q + 1'b1;
          remain_d   = remain_q - 1'b1;
          wr_addr_d  = rd_addr_q;
          first_wr_d = first_q;
          first_d    = 1'b0;
          pend_d     = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          ram_we_o = 1'b1;
        end
        if ((remain_q == '0) && !pend_q) begin
          state_d = cca_pkg::ST_IDLE;
        end
      end

      cca_pkg::ST_READ: begin
        // RAM output holds until the result register frees up
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_entry_d = in_range_q ? cur_e : '0;
          out_total_d = total_q;
          state_d     = cca_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cca_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cca_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      cursor_q    <= '0;
      clip_q      <= '0;
      active_q    <= 1'b0;
      total_q     <= '0;
      remain_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      cursor_q    <= cursor_d;
      clip_q      <= clip_d;
      active_q    <= active_d;
      total_q     <= total_d;
      remain_q    <= remain_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q       <= len_d;
    inc_depth_q <= inc_depth_d;
    add_clip_q  <= add_clip_d;
    add_del_q   <= add_del_d;
    add_ins_q   <= add_ins_d;
    add_total_q <= add_total_d;
    advance_q   <= advance_d;
    walk_q      <= walk_d;
    rd_addr_q   <= rd_addr_d;
    wr_addr_q   <= wr_addr_d;
    first_q     <= first_d;
    first_wr_q  <= first_wr_d;
    in_range_q  <= in_range_d;
    out_entry_q <= out_entry_d;
    out_total_q <= out_total_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.depth         = out_entry_q.depth;
  assign out_o.ins_sum       = out_entry_q.ins_sum;
  assign out_o.del_sum       = out_entry_q.del_sum;
  assign out_o.clip_sum      = out_entry_q.clip_sum;
  assign out_o.aligned_total = out_total_q;

  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we_o && ram_re_o) |-> (ram_waddr_o != ram_raddr_o))
    else $error("table read and write hit the same entry");

  a_writeback_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(ram_re_o))
    else $error("write-back without a preceding read");

  a_span_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_done_i |-> (state_q == cca_pkg::ST_SPAN))
    else $error("span result outside the span wait");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == cca_pkg::ST_READ))
    else $error("result raised without a read-out");

endmodule
